// ===== design/dbm_pkg.sv =====
// Shared types, codes and constant tables of the deterministic buffer mutator.
package dbm_pkg;

  // Width of an effective mutation length and of a buffer position.
  localparam int LenW = 13;

  // Stream payload widths, padded to whole bytes.
  localparam int InDataW  = 40;
  localparam int OutDataW = 56;

  // Reciprocals that split a 32-bit seed by 255 and by 33: quotient = (seed * recip) >> shift.
  localparam logic [31:0] IncRecip  = 32'h8080_8081;
  localparam int          IncShift  = 39;
  localparam logic [31:0] SpecRecip = 32'h3E0F_83E1;
  localparam int          SpecShift = 35;

  typedef enum logic [1:0] {
    OP_LOAD   = 2'd0,
    OP_MUTATE = 2'd1,
    OP_READ   = 2'd2,
    OP_NOP    = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    MODE_INC     = 2'd0,
    MODE_FLIP    = 2'd1,
    MODE_SPECIAL = 2'd2,
    MODE_UNSUP   = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    STAT_DONE     = 2'd0,
    STAT_NO_FIT   = 2'd1,
    STAT_UNSUP    = 2'd2,
    STAT_ZERO_LEN = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    REG_MODE  = 2'd0,
    REG_LIMIT = 2'd1,
    REG_SEED  = 2'd2,
    REG_NONE  = 2'd3
  } reg_idx_e;

  // Result of the serial divider, valid in the cycle that done is high.
  typedef struct packed {
    logic            done;
    logic [LenW-1:0] rem;
  } div_res_t;

  // Size in bytes of boundary constant k.
  function automatic logic [3:0] special_size(input logic [5:0] k);
    logic [3:0] sz;
    if (k < 6'd9) begin
      sz = 4'd1;
    end else if (k < 6'd17) begin
      sz = 4'd2;
    end else if (k < 6'd25) begin
      sz = 4'd4;
    end else begin
      sz = 4'd8;
    end
    return sz;
  endfunction

  // Value of boundary constant k, written little-endian.
  function automatic logic [63:0] special_value(input logic [5:0] k);
    logic [63:0] v;
    case (k)
      6'd0:  v = 64'h00;
      6'd1:  v = 64'h01;
      6'd2:  v = 64'h7E;
      6'd3:  v = 64'h7F;
      6'd4:  v = 64'h80;
      6'd5:  v = 64'h81;
      6'd6:  v = 64'hF0;
      6'd7:  v = 64'hFE;
      6'd8:  v = 64'hFF;
      6'd9:  v = 64'h0000;
      6'd10: v = 64'h0001;
      6'd11: v = 64'h7FFE;
      6'd12: v = 64'h7FFF;
      6'd13: v = 64'h8000;
      6'd14: v = 64'h8001;
      6'd15: v = 64'hFFFE;
      6'd16: v = 64'hFFFF;
      6'd17: v = 64'h0000_0000;
      6'd18: v = 64'h0000_0001;
      6'd19: v = 64'h7FFF_FFFE;
      6'd20: v = 64'h7FFF_FFFF;
      6'd21: v = 64'h8000_0000;
      6'd22: v = 64'h8000_0001;
      6'd23: v = 64'hFFFF_FFFE;
      6'd24: v = 64'hFFFF_FFFF;
      6'd25: v = 64'h0000_0000_0000_0000;
      6'd26: v = 64'h0000_0000_0000_0001;
      6'd27: v = 64'h7FFF_FFFF_FFFF_FFFE;
      6'd28: v = 64'h7FFF_FFFF_FFFF_FFFF;
      6'd29: v = 64'h8000_0000_0000_0000;
      6'd30: v = 64'h8000_0000_0000_0001;
      6'd31: v = 64'hFFFF_FFFF_FFFF_FFFE;
      6'd32: v = 64'hFFFF_FFFF_FFFF_FFFF;
      default: v = 64'h0;
    endcase
    return v;
  endfunction

endpackage

// ===== design/dbm_div.sv =====
// Restoring serial divider: 32-bit dividend by a 13-bit divisor, one bit a cycle.
module dbm_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [31:0]               dividend_i,
  input  logic [dbm_pkg::LenW-1:0]  divisor_i,
  output dbm_pkg::div_res_t         res_o
);
  import dbm_pkg::*;

  logic            busy_q;
  logic [4:0]      cnt_q;
  logic            done_q;
  logic [31:0]     quot_q;
  logic [LenW-1:0] rem_q;
  logic [LenW-1:0] dvs_q;

  logic [LenW:0]   trial;
  logic            fits;
  logic [LenW-1:0] rem_next;

  // One trial subtraction per cycle.
  assign trial    = {rem_q, quot_q[31]};
  assign fits     = trial >= {1'b0, dvs_q};
  assign rem_next = fits ? LenW'(trial - {1'b0, dvs_q}) : trial[LenW-1:0];

  // Step control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 5'd1;
        if (cnt_q == 5'd31) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Quotient and partial remainder.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quot_q <= dividend_i;
      rem_q  <= '0;
      dvs_q  <= divisor_i;
    end else if (busy_q) begin
      quot_q <= {quot_q[30:0], fits};
      rem_q  <= rem_next;
    end
  end

  assign res_o.done = done_q;
  assign res_o.rem  = rem_q;

endmodule

// ===== design/deterministic_buffer_mutator_top.sv =====
// Deterministic buffer mutator: byte store with load, read and seeded mutation items.
// Flow: bit flip, increment and special value wait on the serial modulo by the length, and
// special value then writes one constant byte per cycle; increment and special value first
// split the seed by 255 or 33 in a reciprocal-multiply step.
// Throughput: one item at a time; the next item is taken once the previous result is queued.
// Reset: asynchronous, active low; mode 0, length limit 4096, seed 0; store contents undefined.
module deterministic_buffer_mutator_top #(
  parameter int MAX_LEN = 4096
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input items.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // tdata fields from bit 0: byte_index[11:0], byte_value[7:0], buffer_length[15:0], pad.
  input  logic [39:0] s_axis_tdata,
  // tuser fields from bit 0: op[1:0].
  input  logic [1:0]  s_axis_tuser,
  // Result items.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // tdata fields from bit 0: read_byte[7:0], status[1:0], mutated_position[11:0],
  // seed_used[31:0], pad.
  output logic [55:0] m_axis_tdata,
  // Configuration writes.
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);
  import dbm_pkg::*;

  localparam int          AW       = $clog2(MAX_LEN);
  localparam logic [31:0] MaxLen32 = 32'(MAX_LEN);

  typedef enum logic [6:0] {
    S_IDLE    = 7'b0000001,
    S_READ    = 7'b0000010,
    S_DIV1    = 7'b0000100,
    S_DIV2    = 7'b0001000,
    S_MODIFY  = 7'b0010000,
    S_SPECIAL = 7'b0100000,
    S_DONE    = 7'b1000000
  } state_e;

  state_e          state_q, state_d;
  mode_e           mode_q, mode_d;
  logic [12:0]     limit_q, limit_d;
  logic [31:0]     seed_q, seed_d;
  logic [LenW-1:0] len_q, len_d;
  logic [LenW-1:0] pos_q, pos_d;
  logic [7:0]      r_q, r_d;
  logic [2:0]      wi_q, wi_d;
  logic            rd_ok_q, rd_ok_d;
  logic [7:0]      res_rd_q, res_rd_d;
  status_e         res_st_q, res_st_d;
  logic [11:0]     res_pos_q, res_pos_d;
  logic [31:0]     res_seed_q, res_seed_d;
  logic            out_valid_q;
  logic [55:0]     out_data_q;
  logic            out_load;

  logic            mem_we, mem_re;
  logic [AW-1:0]   mem_waddr, mem_raddr;
  logic [7:0]      mem_wdata, mem_rdata_q;
  logic [7:0]      byte_store [MAX_LEN];

  logic            div_start;
  logic [31:0]     div_dividend;
  logic [LenW-1:0] div_divisor;
  div_res_t        div_res;

  logic [31:0]     split_recip;
  logic [63:0]     split_prod;
  logic [31:0]     split_quot;
  logic [7:0]      split_rem;

  op_e             in_op;
  logic [11:0]     in_idx;
  logic [7:0]      in_val;
  logic [15:0]     in_blen;
  logic            in_acc;
  logic            idx_ok;
  logic [LenW-1:0] len_a, len_c;
  logic [3:0]      spec_sz;
  logic [63:0]     spec_val;

  assign in_idx  = s_axis_tdata[11:0];
  assign in_val  = s_axis_tdata[19:12];
  assign in_blen = s_axis_tdata[35:20];
  assign in_op   = op_e'(s_axis_tuser);

  assign s_axis_tready = (state_q == S_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;

  assign idx_ok = 32'(in_idx) < MaxLen32;

  // Effective length: the item's length clipped to the limit and the store size.
  assign len_a = (32'(in_blen) > 32'(limit_q)) ? limit_q : in_blen[LenW-1:0];
  assign len_c = (32'(len_a) > MaxLen32) ? LenW'(MAX_LEN) : len_a;

  assign spec_sz  = special_size(r_q[5:0]);
  assign spec_val = special_value(r_q[5:0]);

  // Seed split by 255 or 33 through a reciprocal multiply; the remainder is below 255,
  // so only the low byte of seed - quotient * divisor is needed.
  assign split_recip = (mode_q == MODE_SPECIAL) ? SpecRecip : IncRecip;
  assign split_prod  = {32'd0, res_seed_q} * {32'd0, split_recip};
  assign split_quot  = (mode_q == MODE_SPECIAL) ? 32'(split_prod[63:SpecShift])
                                                : 32'(split_prod[63:IncShift]);
  assign split_rem   = (mode_q == MODE_SPECIAL)
                       ? res_seed_q[7:0] - (split_quot[7:0] + {split_quot[2:0], 5'b00000})
                       : res_seed_q[7:0] + split_quot[7:0];

  dbm_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .res_o      (div_res)
  );

  // Sequencer: picks memory accesses and divider runs for each item.
  always_comb begin
    state_d      = state_q;
    mode_d       = mode_q;
    limit_d      = limit_q;
    seed_d       = seed_q;
    len_d        = len_q;
    pos_d        = pos_q;
    r_d          = r_q;
    wi_d         = wi_q;
    rd_ok_d      = rd_ok_q;
    res_rd_d     = res_rd_q;
    res_st_d     = res_st_q;
    res_pos_d    = res_pos_q;
    res_seed_d   = res_seed_q;
    mem_we       = 1'b0;
    mem_waddr    = AW'(in_idx);
    mem_wdata    = in_val;
    mem_re       = 1'b0;
    mem_raddr    = AW'(in_idx);
    div_start    = 1'b0;
    div_dividend = seed_q;
    div_divisor  = len_q;
    out_load     = 1'b0;

    // Configuration writes must arrive only while idle; the sequencer itself does not enforce it.
    if (cfg_valid_i) begin
      unique case (reg_idx_e'(cfg_index_i))
        REG_MODE:  mode_d  = mode_e'(cfg_data_i[1:0]);
        REG_LIMIT: limit_d = cfg_data_i[12:0];
        REG_SEED:  seed_d  = cfg_data_i;
        default:   ;
      endcase
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          res_rd_d   = 8'd0;
          res_st_d   = STAT_DONE;
          res_pos_d  = 12'd0;
          res_seed_d = 32'd0;
          rd_ok_d    = idx_ok;
          state_d    = S_DONE;
          unique case (in_op)
            OP_LOAD: begin
              mem_we = idx_ok;
            end
            OP_READ: begin
              mem_re  = 1'b1;
              state_d = S_READ;
            end
            OP_MUTATE: begin
              if (mode_q == MODE_UNSUP) begin
                res_st_d = STAT_UNSUP;
              end else begin
                seed_d     = seed_q + 32'd1;
                res_seed_d = seed_q;
                len_d      = len_c;
                if (len_c == '0) begin
                  res_st_d = STAT_ZERO_LEN;
                end else if (mode_q == MODE_FLIP) begin
                  div_start    = 1'b1;
                  div_dividend = {3'b000, seed_q[31:3]};
                  div_divisor  = len_c;
                  state_d      = S_DIV2;
                end else begin
                  state_d = S_DIV1;
                end
              end
            end
            default: ;
          endcase
        end
      end
      S_READ: begin
        res_rd_d = rd_ok_q ? mem_rdata_q : 8'd0;
        state_d  = S_DONE;
      end
      S_DIV1: begin
        // Quotient by the constant goes on to the modulo by the length.
        r_d          = split_rem;
        div_start    = 1'b1;
        div_dividend = split_quot;
        div_divisor  = len_q;
        state_d      = S_DIV2;
      end
      S_DIV2: begin
        if (div_res.done) begin
          pos_d     = div_res.rem;
          res_pos_d = div_res.rem[11:0];
          wi_d      = 3'd0;
          if (mode_q == MODE_SPECIAL) begin
            if ((len_q - div_res.rem) < LenW'(spec_sz)) begin
              res_st_d = STAT_NO_FIT;
              state_d  = S_DONE;
            end else begin
              state_d = S_SPECIAL;
            end
          end else begin
            mem_re    = 1'b1;
            mem_raddr = AW'(div_res.rem);
            state_d   = S_MODIFY;
          end
        end
      end
      S_MODIFY: begin
        mem_we    = 1'b1;
        mem_waddr = AW'(pos_q);
        if (mode_q == MODE_FLIP) begin
          mem_wdata = mem_rdata_q ^ (8'd1 << res_seed_q[2:0]);
        end else begin
          mem_wdata = mem_rdata_q + r_q + 8'd1;
        end
        state_d = S_DONE;
      end
      S_SPECIAL: begin
        // One constant byte per cycle, lowest byte first.
        mem_we    = 1'b1;
        mem_waddr = AW'(pos_q + LenW'(wi_q));
        mem_wdata = spec_val[{wi_q, 3'b000} +: 8];
        if (4'(wi_q) == spec_sz - 4'd1) begin
          state_d = S_DONE;
        end else begin
          wi_d = wi_q + 3'd1;
        end
      end
      S_DONE: begin
        if (!out_valid_q || m_axis_tready) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Control and configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      mode_q      <= MODE_INC;
      limit_q     <= 13'd4096;
      seed_q      <= 32'd0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      mode_q  <= mode_d;
      limit_q <= limit_d;
      seed_q  <= seed_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Working and result payload registers.
  always_ff @(posedge clk_i) begin
    len_q      <= len_d;
    pos_q      <= pos_d;
    r_q        <= r_d;
    wi_q       <= wi_d;
    rd_ok_q    <= rd_ok_d;
    res_rd_q   <= res_rd_d;
    res_st_q   <= res_st_d;
    res_pos_q  <= res_pos_d;
    res_seed_q <= res_seed_d;
    if (out_load) begin
      out_data_q <= {2'b00, res_seed_q, res_pos_q, res_st_q, res_rd_q};
    end
  end

  // Byte store: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      byte_store[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata_q <= byte_store[mem_raddr];
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule
